>>> rtl/nlpm_pkg.sv
// Shared types, codes and defaults for the NFA longest-prefix matcher.
package nlpm_pkg;

   localparam int NUM_STATES_DEF  = 32;
   localparam int LENGTH_BITS_DEF = 16;

   // Input operation codes.
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_FEED = 2'd1;
   localparam logic [1:0] OP_END  = 2'd2;
   // Reserved code: the item is dropped with no effect.
   localparam logic [1:0] OP_RSVD = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_START_INDEX = 1'b0;
   localparam logic CSR_ACCEPT_MASK = 1'b1;

   localparam logic [15:0] PREFIX_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0] operation;
      logic [4:0] from_index;
      logic [7:0] symbol;
      logic [4:0] to_index;
   } req_type;

   typedef struct packed {
      logic        matched;
      logic [15:0] prefix_length;
      logic [31:0] accepted_set;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_FEED = 2'd1,
      CMD_END  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [4:0]   from_index;
      logic [7:0]   symbol;
      logic [4:0]   to_index;
   } cmd_type;

endpackage

>>> rtl/nfa_longest_prefix_matcher.sv
// Top level of the NFA longest-prefix matcher: front queue, engine, output slot.
// After reset the block clears all NUM_STATES*256 entries (8192 at the default)
// of its transition memory, one entry a cycle, with full held high. An added
// transition then reads one entry, then merges and writes it back. A fed byte
// takes one pass over all NUM_STATES states to read the byte's entries, then a
// closure worklist that scans the states round robin and reads the epsilon
// entry of each newly reached state once. The first byte of a match also
// computes the closure of the start state first. Results wait in a one-entry
// output register; a two-entry command queue in front lets input arrive while
// the engine works.
module nfa_longest_prefix_matcher #(
   parameter int NUM_STATES  = nlpm_pkg::NUM_STATES_DEF,
   parameter int LENGTH_BITS = nlpm_pkg::LENGTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  nlpm_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output nlpm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import nlpm_pkg::*;

   logic    busy;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    out_free;
   logic    res_valid;
   rsp_type res_data;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   nlpm_front #(
      .NUM_STATES(NUM_STATES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .busy     (busy),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop)
   );

   nlpm_engine #(
      .NUM_STATES (NUM_STATES),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .busy     (busy),
      .out_free (out_free),
      .res_valid(res_valid),
      .res_data (res_data)
   );

   // Output slot frees on the cycle its result transfers.
   assign out_free = !rsp_valid_ff || pop;
   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/nlpm_front.sv
// Input side: accepts items, drops those with no effect, queues commands.
module nlpm_front #(
   parameter int NUM_STATES = nlpm_pkg::NUM_STATES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  nlpm_pkg::req_type req_data,
   input  logic              busy,
   output logic              cmd_valid,
   output nlpm_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import nlpm_pkg::*;

   cmd_type    fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       keep;
   logic       do_pop;
   cmd_type    cls;

   assign full   = (count_ff == 2'd2) || busy;
   assign accept = push && !full;

   // Classify: unknown operations and out-of-range transitions have no effect.
   always_comb begin
      cls.from_index = req_data.from_index;
      cls.symbol     = req_data.symbol;
      cls.to_index   = req_data.to_index;
      cls.kind       = CMD_ADD;
      keep           = 1'b0;
      unique case (req_data.operation)
         OP_ADD: begin
            cls.kind = CMD_ADD;
            keep = (32'(req_data.from_index) < NUM_STATES) &&
                   (32'(req_data.to_index) < NUM_STATES);
         end
         OP_FEED: begin
            cls.kind = CMD_FEED;
            keep     = 1'b1;
         end
         OP_END: begin
            cls.kind = CMD_END;
            keep     = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = fifo_ff[rd_ptr_ff];
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if ((accept && keep) && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!(accept && keep) && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         fifo_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("command queue count out of range");

endmodule

>>> rtl/nlpm_engine.sv
// Back side: transition memory, set stepping, closure worklist and match tracking.
module nlpm_engine #(
   parameter int NUM_STATES  = nlpm_pkg::NUM_STATES_DEF,
   parameter int LENGTH_BITS = nlpm_pkg::LENGTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic              cmd_valid,
   input  nlpm_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              busy,
   input  logic              out_free,
   output logic              res_valid,
   output nlpm_pkg::rsp_type res_data
);
   import nlpm_pkg::*;

   localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int AW    = SW + 8;
   localparam int DEPTH = NUM_STATES * 256;
   localparam int N     = NUM_STATES;
   localparam int LW    = LENGTH_BITS;

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_ADD_WR   = 8'b0000_0100,
      ST_MOVE     = 8'b0000_1000,
      ST_MOVE_END = 8'b0001_0000,
      ST_CLOSE    = 8'b0010_0000,
      ST_POST     = 8'b0100_0000,
      ST_REPORT   = 8'b1000_0000
   } fsm_phase_type;

   logic [N-1:0] mem [DEPTH];

   fsm_phase_type state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [N-1:0] set_ff, set_in;
   logic [N-1:0] pend_ff, pend_in;
   logic [N-1:0] next_ff, next_in;
   logic         arming_ff, arming_in;
   cmd_type      cur_ff, cur_in;
   logic         running_ff, running_in;
   logic         best_valid_ff, best_valid_in;
   logic [N-1:0] best_set_ff, best_set_in;
   logic [LW-1:0] best_len_ff, best_len_in;
   logic [LW-1:0] consumed_ff, consumed_in;
   logic [4:0]   start_ff;
   logic [31:0]  accept_ff;
   logic         rd_valid_ff;
   logic [N-1:0] rd_data_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [N-1:0]  mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;

   logic [N-1:0]  accepting;
   logic [N-1:0]  hit;
   logic [N-1:0]  start_set;
   logic [N-1:0]  merged;
   logic [N-1:0]  pend_w;
   logic [N-1:0]  rd_or;
   logic [LW-1:0] consumed_inc;
   logic [SW-1:0] cnt_next;

   assign accepting = N'(accept_ff);
   assign hit       = set_ff & accepting;
   assign start_set = (32'(start_ff) < NUM_STATES) ? (N'(1) << SW'(start_ff)) : '0;
   assign rd_or     = rd_valid_ff ? rd_data_ff : '0;
   assign merged    = rd_or & ~set_ff;
   assign pend_w    = pend_ff | merged;
   assign cnt_next  = (cnt_ff == SW'(NUM_STATES - 1)) ? '0 : cnt_ff + SW'(1);
   assign consumed_inc = (consumed_ff == '1) ? consumed_ff : consumed_ff + LW'(1);
   assign busy      = (state_ff == ST_CLEAR);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cnt_in        = cnt_ff;
      set_in        = set_ff;
      pend_in       = pend_ff;
      next_in       = next_ff;
      arming_in     = arming_ff;
      cur_in        = cur_ff;
      running_in    = running_ff;
      best_valid_in = best_valid_ff;
      best_set_in   = best_set_ff;
      best_len_in   = best_len_ff;
      consumed_in   = consumed_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      cmd_pop       = 1'b0;
      res_valid     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               cnt_in  = '0;
               next_in = '0;
               if (cmd.kind == CMD_ADD) begin
                  mem_re    = 1'b1;
                  mem_raddr = {SW'(cmd.from_index), cmd.symbol};
                  state_in  = ST_ADD_WR;
               end else if (!running_ff) begin
                  set_in    = start_set;
                  pend_in   = start_set;
                  arming_in = 1'b1;
                  state_in  = ST_CLOSE;
               end else if (cmd.kind == CMD_FEED) begin
                  state_in = ST_MOVE;
               end else begin
                  state_in = ST_REPORT;
               end
            end
         end
         ST_ADD_WR: begin
            mem_we    = 1'b1;
            mem_waddr = {SW'(cur_ff.from_index), cur_ff.symbol};
            mem_wdata = rd_data_ff | (N'(1) << SW'(cur_ff.to_index));
            state_in  = ST_IDLE;
         end
         ST_MOVE: begin
            next_in = next_ff | rd_or;
            if (set_ff[cnt_ff]) begin
               mem_re    = 1'b1;
               mem_raddr = {cnt_ff, cur_ff.symbol};
            end
            cnt_in = cnt_next;
            if (cnt_ff == SW'(NUM_STATES - 1)) begin
               state_in = ST_MOVE_END;
            end
         end
         ST_MOVE_END: begin
            set_in   = next_ff | rd_or;
            pend_in  = next_ff | rd_or;
            cnt_in   = '0;
            state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            // Worklist: each newly reached state is expanded once along epsilon.
            if ((pend_ff == '0) && !rd_valid_ff) begin
               state_in = ST_POST;
            end else begin
               set_in  = set_ff | merged;
               pend_in = pend_w;
               if (pend_w[cnt_ff]) begin
                  mem_re          = 1'b1;
                  mem_raddr       = {cnt_ff, 8'd0};
                  pend_in[cnt_ff] = 1'b0;
               end
               cnt_in = cnt_next;
            end
         end
         ST_POST: begin
            if (arming_ff) begin
               arming_in     = 1'b0;
               running_in    = 1'b1;
               consumed_in   = '0;
               best_valid_in = (hit != '0);
               best_set_in   = hit;
               best_len_in   = '0;
               cnt_in        = '0;
               next_in       = '0;
               state_in      = (cur_ff.kind == CMD_FEED) ? ST_MOVE : ST_REPORT;
            end else begin
               consumed_in = consumed_inc;
               if (set_ff == '0) begin
                  state_in = ST_REPORT;
               end else begin
                  if (hit != '0) begin
                     best_valid_in = 1'b1;
                     best_set_in   = hit;
                     best_len_in   = consumed_inc;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPORT: begin
            res_valid  = 1'b1;
            running_in = 1'b0;
            set_in     = '0;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      res_data = '0;
      if (best_valid_ff) begin
         res_data.matched       = 1'b1;
         res_data.prefix_length = (32'(best_len_ff) > 32'(PREFIX_MAX)) ?
                                  PREFIX_MAX : 16'(best_len_ff);
         res_data.accepted_set  = 32'(best_set_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pend_ff     <= pend_in;
      next_ff     <= next_in;
      cur_ff      <= cur_in;
      best_set_ff <= best_set_in;
      best_len_ff <= best_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         set_ff        <= '0;
         arming_ff     <= 1'b0;
         running_ff    <= 1'b0;
         best_valid_ff <= 1'b0;
         consumed_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         start_ff      <= '0;
         accept_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         set_ff        <= set_in;
         arming_ff     <= arming_in;
         running_ff    <= running_in;
         best_valid_ff <= best_valid_in;
         consumed_ff   <= consumed_in;
         rd_valid_ff   <= mem_re;
         if (csr_we) begin
            if (csr_index == CSR_START_INDEX) begin
               start_ff <= csr_wdata[4:0];
            end else begin
               accept_ff <= csr_wdata;
            end
         end
      end
   end

   a_report_slot: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result produced with output slot occupied");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !cmd_pop)
      else $error("command taken during clearing pass");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && !running_ff) |-> (set_ff == '0))
      else $error("active set not empty while no match runs");

endmodule

>>> bench/nlpm_checker.sv
// Checker for the NFA longest-prefix matcher: predicts results and compares them.
module nlpm_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  nlpm_pkg::req_type req_data,
   input  logic              empty,
   input  logic              pop,
   input  nlpm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                pending_count
);
   import nlpm_pkg::*;

   localparam int STATES = NUM_STATES_DEF;

   logic [31:0] next_table [0:STATES*256-1];
   logic [31:0] live_set;
   logic [31:0] best_states;
   logic [15:0] best_len;
   logic [15:0] eaten_len;
   logic        best_ok;
   logic        running;
   logic [4:0]  start_idx;
   logic [31:0] accept_states;
   rsp_type     match_queue [$];

   function automatic logic [31:0] step_set(logic [31:0] set, logic [7:0] sym);
      logic [31:0] nxt;
      nxt = '0;
      for (int s = 0; s < STATES; s++)
         if (set[s]) nxt |= next_table[s*256 + sym];
      return nxt;
   endfunction

   function automatic logic [31:0] eps_closure(logic [31:0] set);
      logic [31:0] grown;
      for (int i = 0; i <= STATES; i++) begin
         grown = set | step_set(set, 8'd0);
         if (grown == set) break;
         set = grown;
      end
      return set;
   endfunction

   task automatic note_accept();
      if ((live_set & accept_states) != 0) begin
         best_ok     = 1'b1;
         best_states = live_set & accept_states;
         best_len    = eaten_len;
      end
   endtask

   task automatic start_match();
      live_set = eps_closure(32'd1 << start_idx);
      best_ok = 1'b0;
      best_states = '0;
      best_len = '0;
      eaten_len = '0;
      running = 1'b1;
      note_accept();
   endtask

   task automatic emit_match();
      rsp_type r;
      r.matched       = best_ok;
      r.prefix_length = best_ok ? best_len : 16'd0;
      r.accepted_set  = best_ok ? best_states : 32'd0;
      match_queue.insert(match_queue.size(), r);
      running = 1'b0;
      live_set = '0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < STATES*256; i++) next_table[i] = '0;
         live_set = '0; best_states = '0; best_len = '0; eaten_len = '0;
         best_ok = 1'b0; running = 1'b0; start_idx = '0; accept_states = '0;
         match_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_START_INDEX) start_idx = csr_wdata[4:0];
            else accept_states = csr_wdata;
         end
         if (!empty && pop) begin
            if (match_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $realtime, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = match_queue.pop_front();
               if (want.matched !== rsp_data.matched ||
                   want.prefix_length !== rsp_data.prefix_length ||
                   want.accepted_set !== rsp_data.accepted_set) begin
                  $display("%0t: expected %b/%0d/%h actual %b/%0d/%h", $realtime,
                           want.matched, want.prefix_length, want.accepted_set,
                           rsp_data.matched, rsp_data.prefix_length,
                           rsp_data.accepted_set);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (push && !full) begin
            case (req_data.operation)
               OP_ADD: begin
                  next_table[req_data.from_index*256 + req_data.symbol]
                     [req_data.to_index] = 1'b1;
               end
               OP_FEED: begin
                  if (!running) start_match();
                  live_set = eps_closure(step_set(live_set, req_data.symbol));
                  if (eaten_len != 16'hFFFF) eaten_len = eaten_len + 16'd1;
                  if (live_set == 0) emit_match();
                  else note_accept();
               end
               OP_END: begin
                  if (!running) start_match();
                  emit_match();
               end
               default: ;
            endcase
         end
      end
      pending_count <= match_queue.size();
   end
endmodule

>>> bench/tb.sv
// Testbench top: stimulus, configuration phases and verdict for the matcher.
module tb;
   import nlpm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   req_type     req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_START_INDEX;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          send_idle = 38;
   int          take_idle = 46;

   always #10 clock = ~clock;

   nfa_longest_prefix_matcher u_top (
      .clock, .reset, .push, .full, .req_data, .empty, .pop, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   nlpm_checker u_checker (
      .clock, .reset, .push, .full, .req_data, .empty, .pop, .rsp_data,
      .csr_we, .csr_index, .csr_wdata, .fail_count, .pending_count
   );

   always @(posedge clock)
      pop <= ($urandom_range(99) >= take_idle);

   // Push stays high after a transfer so the next item can follow at once.
   task automatic send(logic [1:0] op, logic [4:0] from, logic [7:0] sym, logic [4:0] to);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= '{operation: op, from_index: from, symbol: sym, to_index: to};
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // Close the stream: once its result arrives every earlier item has finished.
   task automatic drain();
      send(OP_END, 5'd0, 8'd0, 5'd0);
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || !empty) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random lexer-like stream: small alphabet so matches grow deep.
   task automatic random_phase(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 12)
            send(OP_ADD, 5'($urandom_range(7)), ($urandom_range(3) == 0) ? 8'd0 :
                 8'($urandom_range(1, 4)), 5'($urandom_range(7)));
         else if (k < 15)
            send(OP_ADD, 5'($urandom), 8'($urandom), 5'($urandom));
         else if (k < 80)
            send(OP_FEED, 5'($urandom), ($urandom_range(19) == 0) ? 8'($urandom) :
                 8'($urandom_range(1, 4)), 5'($urandom));
         else if (k < 96)
            send(OP_END, 5'($urandom), 8'($urandom), 5'($urandom));
         else
            send(OP_RSVD, 5'($urandom), 8'($urandom), 5'($urandom));
      end
   endtask

   initial begin
      #1000000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_START_INDEX, 32'd0);
      write_reg(CSR_ACCEPT_MASK, 32'h0000_0004);
      // Directed: empty stream, no match, chain with epsilon, byte zero, extremes.
      send(OP_END, 5'd0, 8'd0, 5'd0);
      send(OP_FEED, 5'd0, 8'd1, 5'd0);
      send(OP_ADD, 5'd0, 8'd1, 5'd1);
      send(OP_ADD, 5'd1, 8'd0, 5'd2);
      send(OP_ADD, 5'd2, 8'd255, 5'd2);
      send(OP_ADD, 5'd31, 8'd0, 5'd31);
      send(OP_ADD, 5'd2, 8'd0, 5'd31);
      send(OP_FEED, 5'd31, 8'd1, 5'd31);
      send(OP_FEED, 5'd0, 8'd255, 5'd0);
      send(OP_FEED, 5'd0, 8'd255, 5'd0);
      send(OP_FEED, 5'd0, 8'd7, 5'd0);
      send(OP_ADD, 5'd3, 8'd0, 5'd4);
      send(OP_FEED, 5'd0, 8'd0, 5'd0);
      send(OP_RSVD, 5'd31, 8'd255, 5'd31);
      send(OP_FEED, 5'd0, 8'd1, 5'd0);
      send(OP_END, 5'd31, 8'd255, 5'd31);
      drain();
      write_reg(CSR_START_INDEX, 32'd31);
      write_reg(CSR_ACCEPT_MASK, 32'hFFFF_FFFF);
      send(OP_END, 5'd0, 8'd0, 5'd0);
      send(OP_FEED, 5'd0, 8'd0, 5'd0);
      send(OP_FEED, 5'd0, 8'd9, 5'd0);
      drain();
      write_reg(CSR_START_INDEX, 32'd0);
      write_reg(CSR_ACCEPT_MASK, 32'h0000_00A4);
      random_phase(420);
      drain();
      send_idle = 46;
      take_idle = 38;
      write_reg(CSR_START_INDEX, 32'd1);
      write_reg(CSR_ACCEPT_MASK, $urandom);
      random_phase(410);
      drain();
      send_idle = 0;
      take_idle = 0;
      write_reg(CSR_START_INDEX, 32'd0);
      write_reg(CSR_ACCEPT_MASK, 32'h0000_00F0);
      random_phase(410);
      drain();
      if (fail_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

>>> files.f
rtl/nlpm_pkg.sv
rtl/nlpm_front.sv
rtl/nlpm_engine.sv
rtl/nfa_longest_prefix_matcher.sv
bench/nlpm_checker.sv
bench/tb.sv
